@@ rtl/cpsc_pkg.sv @@
// ----------------------------------------------------------------------------
// cpsc_pkg - cascaded position / speed controller package
// Fixed-point format, filter coefficients, register indexes and sequencer
// state codes shared by the controller.
// ----------------------------------------------------------------------------
`default_nettype none

package cpsc_pkg;

  // fixed-point format and pwm scale
  localparam int FRAC_BITS = 16;
  localparam int PWM_TOP   = 3999;

  // q0.32 encoder scale brought to q format
  localparam int SHIFT_Q32 = 32 - FRAC_BITS;
  // full-scale command, 3 V
  localparam int VMAX      = 3 << FRAC_BITS;
  localparam int SAT_W     = FRAC_BITS + 3;
  localparam int MAG_W     = FRAC_BITS + 2;

  // field widths
  localparam int DUTY_W  = 12;
  localparam int POS_W   = 48;
  localparam int SPEED_W = 32;
  localparam int VOLT_W  = 19;
  localparam int OUT_W   = 168;

  // biquad coefficients, magnitudes in q2.30 (a1 term is negative)
  localparam logic [31:0] COEF_B0  = 32'd72429545;
  localparam logic [31:0] COEF_B1  = 32'd144859100;
  localparam logic [31:0] COEF_A0M = 32'd1227265967;
  localparam logic [31:0] COEF_A1  = 32'd443242343;

  // divide by three via reciprocal, exact below 2^19
  localparam logic [31:0] RECIP3    = 32'd174763;
  localparam int          RECIP3_SH = 19;

  localparam logic [63:0] POS_CAP = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] S32_CAP = 64'h0000_0000_7FFF_FFFF;

  // configuration register indexes
  localparam logic [7:0] REG_POS_GAIN    = 8'd0;
  localparam logic [7:0] REG_SPEED_KP    = 8'd1;
  localparam logic [7:0] REG_SPEED_KI    = 8'd2;
  localparam logic [7:0] REG_SPEED_KD    = 8'd3;
  localparam logic [7:0] REG_SPEED_LIMIT = 8'd4;
  localparam logic [7:0] REG_DEADBAND    = 8'd5;
  localparam logic [7:0] REG_MOTOR_RPC   = 8'd6;
  localparam logic [7:0] REG_REF_RPC     = 8'd7;

  typedef enum logic [21:0] {
    ST_IDLE      = 22'h000001,
    ST_MUL_TPOS  = 22'h000002,
    ST_GET_TPOS  = 22'h000004,
    ST_GET_POS   = 22'h000008,
    ST_GET_RAW   = 22'h000010,
    ST_ACC_B1    = 22'h000020,
    ST_ACC_B2    = 22'h000040,
    ST_ACC_A1    = 22'h000080,
    ST_ACC_A2    = 22'h000100,
    ST_ACC_B0    = 22'h000200,
    ST_SPEED     = 22'h000400,
    ST_ERR_HI    = 22'h000800,
    ST_TSPEED    = 22'h001000,
    ST_ERRS      = 22'h002000,
    ST_MUL_KP    = 22'h004000,
    ST_GET_P     = 22'h008000,
    ST_GET_I     = 22'h010000,
    ST_GET_D     = 22'h020000,
    ST_CLAMP     = 22'h040000,
    ST_MUL_PWM   = 22'h080000,
    ST_MUL_RECIP = 22'h100000,
    ST_OUT       = 22'h200000
  } state_t;

endpackage

`default_nettype wire

@@ rtl/cascaded_position_speed_controller_top.sv @@
// ----------------------------------------------------------------------------
// cascaded_position_speed_controller_top - cascaded position / speed loop
// Encoder totals, biquad speed filter, p position loop and pi-d speed loop
// with anti-windup, worked through one shared 32x32 multiplier.
//
//  channel   dir  handshake                 content
//  s_*       in   s_tvalid / s_tready       motor and reference counts
//  m_*       out  m_tvalid / m_tready       duty, direction, positions, speed
//  cfg_*     in   cfg_valid / cfg_ready     register index and write data
//
// a beat runs through the whole sequence from acceptance to the result register,
// and a new beat is taken only once the last result is registered; the sequencer
// issues at most one product per cycle into the shared multiplier.
// s_tready is high only while the sequencer is idle; a finished result
// waits in the output register, and the sequencer holds its last step while
// that register is still full. cfg_ready is always high. rst is synchronous.
// ----------------------------------------------------------------------------
`default_nettype none

module cascaded_position_speed_controller_top (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [31:0]  s_tdata,    // motor_count, ref_count
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // pwm_duty, drive_forward, drive_reverse, motor position,
  // reference position, filtered_speed, drive_volts, zero pad
  output logic [167:0]      m_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [7:0]   cfg_index,
  input  wire logic [31:0]  cfg_data
);

  localparam int F = cpsc_pkg::FRAC_BITS;
  localparam logic signed [50:0] VMAX_P = 51'(cpsc_pkg::VMAX);
  localparam logic signed [50:0] VMAX_N = -51'(cpsc_pkg::VMAX);

  cpsc_pkg::state_t state;

  // configuration
  logic [23:0] pos_gain, speed_kp, speed_ki, speed_kd, speed_limit;
  logic [11:0] deadband;
  logic [31:0] motor_rpc, ref_rpc;

  // controller state
  logic [15:0]        motor_last, ref_last;
  logic signed [31:0] mtot, rtot;
  logic signed [31:0] fi0, fi1, fo0, fo1;
  logic signed [31:0] integ, integ_old, last_speed;

  // per-tick working registers
  logic signed [25:0] spd_cnt;
  logic signed [47:0] tpos, pos;
  logic signed [31:0] raw, speed;
  logic signed [63:0] acc;
  logic [48:0]        errmag;
  logic               errneg;
  logic [73:0]        wacc;
  logic signed [24:0] tspeed;
  logic signed [32:0] es, ds;
  logic signed [48:0] pterm, dterm;
  logic signed [cpsc_pkg::SAT_W-1:0] sat;
  logic [cpsc_pkg::MAG_W-1:0]        vmag;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic        sign_in, psign;
  logic [63:0] prod;

  // combinational results
  logic signed [15:0] mdiff, rdiff;
  logic signed [25:0] mdiff_w;
  logic [63:0]        shifted, acc_mag;
  logic signed [47:0] pos_val;
  logic [30:0]        raw_mag;
  logic signed [31:0] raw_val, speed_val;
  logic [34:0]        rnd;
  logic [73:0]        wmag;
  logic [23:0]        tsp_mag;
  logic [47:0]        term_mag;
  logic signed [48:0] term_val;
  logic signed [49:0] isum;
  logic signed [31:0] integ_sat;
  logic signed [50:0] u;
  logic signed [48:0] err_w;
  logic [31:0]        esmag, dsmag;
  logic [15:0]        duty_val;
  logic               drive_off, es_pos, es_neg, sat_pos;

  assign s_tready  = (state == cpsc_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    mdiff   = signed'(s_tdata[15:0] - motor_last);
    rdiff   = signed'(s_tdata[31:16] - ref_last);
    mdiff_w = 26'(mdiff);
    shifted = prod >> cpsc_pkg::SHIFT_Q32;
    pos_val = (shifted > cpsc_pkg::POS_CAP) ? 48'(cpsc_pkg::POS_CAP) : 48'(shifted);
    if (psign) pos_val = -pos_val;
    raw_mag = (shifted > cpsc_pkg::S32_CAP) ? 31'h7FFF_FFFF : shifted[30:0];
    raw_val = psign ? -signed'({1'b0, raw_mag}) : signed'({1'b0, raw_mag});
    acc_mag = acc[63] ? 64'(-acc) : 64'(acc);
    rnd     = 35'((acc_mag + (64'd1 << 29)) >> 30);
    if (rnd > 35'(cpsc_pkg::S32_CAP)) begin
      speed_val = acc[63] ? -32'sh7FFF_FFFF : 32'sh7FFF_FFFF;
    end else begin
      speed_val = acc[63] ? -signed'(rnd[31:0]) : signed'(rnd[31:0]);
    end
    wmag     = wacc >> F;
    tsp_mag  = (wmag > 74'(speed_limit)) ? speed_limit : wmag[23:0];
    term_mag = 48'(prod >> F);
    term_val = psign ? -signed'({1'b0, term_mag}) : signed'({1'b0, term_mag});
    isum     = 50'(integ) + 50'(term_val);
    if (isum > 50'sh7FFF_FFFF) begin
      integ_sat = 32'sh7FFF_FFFF;
    end else if (isum < -50'sh8000_0000) begin
      integ_sat = -32'sh7FFF_FFFF - 32'sd1;
    end else begin
      integ_sat = 32'(isum);
    end
    u        = 51'(pterm) + 51'(integ) + 51'(dterm);
    err_w    = 49'(tpos) - 49'(pos);
    esmag    = es[32] ? 32'(-es) : 32'(es);
    dsmag    = ds[32] ? 32'(-ds) : 32'(ds);
    es_neg   = es[32];
    es_pos   = !es[32] && (es != 33'sd0);
    duty_val = 16'(prod >> cpsc_pkg::RECIP3_SH);
    drive_off = (duty_val < {4'd0, deadband});
    sat_pos  = !sat[cpsc_pkg::SAT_W-1] && (sat != '0);
  end

  // operand selection for the shared multiplier
  always_comb begin
    mul_a   = 32'd0;
    mul_b   = 32'd0;
    sign_in = 1'b0;
    case (state)
      cpsc_pkg::ST_MUL_TPOS: begin
        mul_a = rtot[31] ? 32'(-rtot) : 32'(rtot); mul_b = ref_rpc; sign_in = rtot[31];
      end
      cpsc_pkg::ST_GET_TPOS: begin
        mul_a = mtot[31] ? 32'(-mtot) : 32'(mtot); mul_b = motor_rpc; sign_in = mtot[31];
      end
      cpsc_pkg::ST_GET_POS: begin
        mul_a = spd_cnt[25] ? 32'(-spd_cnt) : 32'(spd_cnt);
        mul_b = motor_rpc; sign_in = spd_cnt[25];
      end
      cpsc_pkg::ST_GET_RAW: begin
        mul_a = fi0[31] ? 32'(-fi0) : 32'(fi0); mul_b = cpsc_pkg::COEF_B1; sign_in = fi0[31];
      end
      cpsc_pkg::ST_ACC_B1: begin
        mul_a = fi1[31] ? 32'(-fi1) : 32'(fi1); mul_b = cpsc_pkg::COEF_B0; sign_in = fi1[31];
      end
      cpsc_pkg::ST_ACC_B2: begin
        mul_a = fo0[31] ? 32'(-fo0) : 32'(fo0); mul_b = cpsc_pkg::COEF_A0M;
        sign_in = fo0[31];
      end
      cpsc_pkg::ST_ACC_A1: begin
        // term enters with a minus sign
        mul_a = fo1[31] ? 32'(-fo1) : 32'(fo1); mul_b = cpsc_pkg::COEF_A1;
        sign_in = !fo1[31];
      end
      cpsc_pkg::ST_ACC_A2: begin
        mul_a = raw[31] ? 32'(-raw) : 32'(raw); mul_b = cpsc_pkg::COEF_B0; sign_in = raw[31];
      end
      cpsc_pkg::ST_ACC_B0: begin
        mul_a = errmag[31:0]; mul_b = 32'(pos_gain);
      end
      cpsc_pkg::ST_SPEED: begin
        mul_a = 32'(errmag[48:32]); mul_b = 32'(pos_gain);
      end
      cpsc_pkg::ST_MUL_KP: begin
        mul_a = esmag; mul_b = 32'(speed_kp); sign_in = es[32];
      end
      cpsc_pkg::ST_GET_P: begin
        mul_a = esmag; mul_b = 32'(speed_ki); sign_in = es[32];
      end
      cpsc_pkg::ST_GET_I: begin
        // derivative on measurement, negated
        mul_a = dsmag; mul_b = 32'(speed_kd); sign_in = !ds[32];
      end
      cpsc_pkg::ST_MUL_PWM: begin
        mul_a = 32'(vmag); mul_b = 32'(cpsc_pkg::PWM_TOP);
      end
      cpsc_pkg::ST_MUL_RECIP: begin
        mul_a = 32'(prod >> F); mul_b = cpsc_pkg::RECIP3;
      end
      default: begin
        mul_a = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state != cpsc_pkg::ST_OUT) begin
      prod <= 64'(mul_a) * 64'(mul_b);
    end
    psign <= sign_in;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_gain    <= 24'd983040;
      speed_kp    <= 24'd327680;
      speed_ki    <= 24'd3277;
      speed_kd    <= 24'd0;
      speed_limit <= 24'd786432;
      deadband    <= 12'd100;
      motor_rpc   <= 32'd7027624;
      ref_rpc     <= 32'd337325943;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cpsc_pkg::REG_POS_GAIN:    pos_gain    <= cfg_data[23:0];
        cpsc_pkg::REG_SPEED_KP:    speed_kp    <= cfg_data[23:0];
        cpsc_pkg::REG_SPEED_KI:    speed_ki    <= cfg_data[23:0];
        cpsc_pkg::REG_SPEED_KD:    speed_kd    <= cfg_data[23:0];
        cpsc_pkg::REG_SPEED_LIMIT: speed_limit <= cfg_data[23:0];
        cpsc_pkg::REG_DEADBAND:    deadband    <= cfg_data[11:0];
        cpsc_pkg::REG_MOTOR_RPC:   motor_rpc   <= cfg_data;
        cpsc_pkg::REG_REF_RPC:     ref_rpc     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= cpsc_pkg::ST_IDLE;
      m_tvalid   <= 1'b0;
      motor_last <= '0;
      ref_last   <= '0;
      mtot       <= '0;
      rtot       <= '0;
      fi0        <= '0;
      fi1        <= '0;
      fo0        <= '0;
      fo1        <= '0;
      integ      <= '0;
      integ_old  <= '0;
      last_speed <= '0;
    end else begin
      if (m_tvalid && m_tready && (state != cpsc_pkg::ST_OUT)) m_tvalid <= 1'b0;
      case (state)
        cpsc_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            motor_last <= s_tdata[15:0];
            ref_last   <= s_tdata[31:16];
            mtot       <= mtot + 32'(mdiff);
            rtot       <= rtot + 32'(rdiff);
            // times 500 as 512 - 16 + 4
            spd_cnt    <= (mdiff_w <<< 9) - (mdiff_w <<< 4) + (mdiff_w <<< 2);
            state      <= cpsc_pkg::ST_MUL_TPOS;
          end
        end
        cpsc_pkg::ST_MUL_TPOS: state <= cpsc_pkg::ST_GET_TPOS;
        cpsc_pkg::ST_GET_TPOS: begin
          tpos  <= pos_val;
          state <= cpsc_pkg::ST_GET_POS;
        end
        cpsc_pkg::ST_GET_POS: begin
          pos   <= pos_val;
          state <= cpsc_pkg::ST_GET_RAW;
        end
        cpsc_pkg::ST_GET_RAW: begin
          raw   <= raw_val;
          acc   <= '0;
          state <= cpsc_pkg::ST_ACC_B1;
        end
        cpsc_pkg::ST_ACC_B1, cpsc_pkg::ST_ACC_B2, cpsc_pkg::ST_ACC_A1,
        cpsc_pkg::ST_ACC_A2, cpsc_pkg::ST_ACC_B0: begin
          acc <= acc + (psign ? -signed'(prod) : signed'(prod));
          case (state)
            cpsc_pkg::ST_ACC_B1: state <= cpsc_pkg::ST_ACC_B2;
            cpsc_pkg::ST_ACC_B2: state <= cpsc_pkg::ST_ACC_A1;
            cpsc_pkg::ST_ACC_A1: state <= cpsc_pkg::ST_ACC_A2;
            cpsc_pkg::ST_ACC_A2: begin
              errmag <= err_w[48] ? 49'(-err_w) : 49'(err_w);
              errneg <= err_w[48];
              state  <= cpsc_pkg::ST_ACC_B0;
            end
            default: state <= cpsc_pkg::ST_SPEED;
          endcase
        end
        cpsc_pkg::ST_SPEED: begin
          speed <= speed_val;
          fi1   <= fi0;
          fi0   <= raw;
          fo1   <= fo0;
          fo0   <= speed_val;
          wacc  <= 74'(prod);
          state <= cpsc_pkg::ST_ERR_HI;
        end
        cpsc_pkg::ST_ERR_HI: begin
          wacc  <= wacc + (74'(prod) << 32);
          state <= cpsc_pkg::ST_TSPEED;
        end
        cpsc_pkg::ST_TSPEED: begin
          tspeed <= errneg ? -signed'({1'b0, tsp_mag}) : signed'({1'b0, tsp_mag});
          state  <= cpsc_pkg::ST_ERRS;
        end
        cpsc_pkg::ST_ERRS: begin
          es         <= 33'(tspeed) - 33'(speed);
          ds         <= 33'(speed) - 33'(last_speed);
          last_speed <= speed;
          state      <= cpsc_pkg::ST_MUL_KP;
        end
        cpsc_pkg::ST_MUL_KP: state <= cpsc_pkg::ST_GET_P;
        cpsc_pkg::ST_GET_P: begin
          pterm <= term_val;
          state <= cpsc_pkg::ST_GET_I;
        end
        cpsc_pkg::ST_GET_I: begin
          integ_old <= integ;
          integ     <= integ_sat;
          state     <= cpsc_pkg::ST_GET_D;
        end
        cpsc_pkg::ST_GET_D: begin
          dterm <= term_val;
          state <= cpsc_pkg::ST_CLAMP;
        end
        cpsc_pkg::ST_CLAMP: begin
          // conditional anti-windup: drop this tick's integral step
          if (u > VMAX_P) begin
            sat  <= cpsc_pkg::SAT_W'(VMAX_P);
            vmag <= cpsc_pkg::MAG_W'(VMAX_P);
            if (es_pos) integ <= integ_old;
          end else if (u < VMAX_N) begin
            sat  <= cpsc_pkg::SAT_W'(VMAX_N);
            vmag <= cpsc_pkg::MAG_W'(VMAX_P);
            if (es_neg) integ <= integ_old;
          end else begin
            sat  <= cpsc_pkg::SAT_W'(u);
            vmag <= u[50] ? cpsc_pkg::MAG_W'(-u) : cpsc_pkg::MAG_W'(u);
          end
          state <= cpsc_pkg::ST_MUL_PWM;
        end
        cpsc_pkg::ST_MUL_PWM: state <= cpsc_pkg::ST_MUL_RECIP;
        cpsc_pkg::ST_MUL_RECIP: state <= cpsc_pkg::ST_OUT;
        cpsc_pkg::ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'd0, cpsc_pkg::VOLT_W'(sat), speed, tpos, pos,
                         !drive_off && !sat_pos, !drive_off && sat_pos,
                         drive_off ? 12'd0 : duty_val[11:0]};
            state <= cpsc_pkg::ST_IDLE;
          end
        end
        default: state <= cpsc_pkg::ST_IDLE;
      endcase
    end
  end

  // busy for the whole sequence after a beat is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while sequence running");

  a_one_direction: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[12] && m_tdata[13]))
    else $error("both direction bits set");

  a_duty_has_direction: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[11:0] != 12'd0)) |-> (m_tdata[12] || m_tdata[13]))
    else $error("duty without direction");

endmodule

`default_nettype wire

@@ tb/cascaded_position_speed_controller_top_tb.sv @@
// ----------------------------------------------------------------------------
// cascaded_position_speed_controller_top_tb - controller self-checking bench
// Drives encoder counts through the stream input, writes the tuning
// registers between phases and compares each result beat field by field
// with a behavioural predictor of the encoder, filter and cascaded loops.
// ----------------------------------------------------------------------------
`default_nettype none

module cascaded_position_speed_controller_top_tb;

  localparam logic [7:0] SPARE_REG_IDX = 8'd9;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [31:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [167:0] m_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  typedef struct packed {
    logic [11:0] duty;
    logic        fwd;
    logic        rev;
    logic [47:0] pos;
    logic [47:0] tpos;
    logic [31:0] speed;
    logic [18:0] volts;
  } drive_beat_t;

  drive_beat_t expected_beats[$];
  int          errors = 0;
  int          beats_sent = 0;
  int          beats_checked = 0;
  int          idle_cycles = 0;
  int          long_gap_pct = 5;
  int          rdy_hold = 0;
  logic        rdy_wait = 1'b0;

  // predictor copy of the registers and loop state
  logic [23:0] gain_pos, gain_kp, gain_ki, gain_kd, lim_speed;
  logic [11:0] db_level;
  logic [31:0] motor_scale, ref_scale;
  logic [15:0] motor_prev, ref_prev;
  logic [31:0] motor_total, ref_total;
  longint      filt_x0, filt_x1, filt_y0, filt_y1, integ, prev_speed;

  always #2 clk = ~clk;

  cascaded_position_speed_controller_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // sign(a) * min(cap, |a|*g >> s); 128-bit product makes overflow exact
  function automatic longint scale_sat(longint a, longint unsigned g, int s,
                                       longint unsigned cap);
    logic [127:0] m, p;
    m = (a < 0) ? 128'(-a) : 128'(a);
    p = (m * 128'(g)) >> s;
    if (p > 128'(cap)) p = 128'(cap);
    return (a < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint wrap_diff(logic [15:0] now, logic [15:0] prev);
    logic [15:0] d;
    d = now - prev;
    return longint'(d[15] ? (int'(d) - 65536) : int'(d));
  endfunction

  function automatic longint clip_s32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void reset_controller_model();
    gain_pos = 24'd983040; gain_kp = 24'd327680; gain_ki = 24'd3277;
    gain_kd = 24'd0; lim_speed = 24'd786432; db_level = 12'd100;
    motor_scale = 32'd7027624; ref_scale = 32'd337325943;
    motor_prev = '0; ref_prev = '0; motor_total = '0; ref_total = '0;
    filt_x0 = 0; filt_x1 = 0; filt_y0 = 0; filt_y1 = 0;
    integ = 0; prev_speed = 0;
  endfunction

  function automatic void write_model_reg(logic [7:0] idx, logic [31:0] val);
    case (idx)
      cpsc_pkg::REG_POS_GAIN:    gain_pos = val[23:0];
      cpsc_pkg::REG_SPEED_KP:    gain_kp = val[23:0];
      cpsc_pkg::REG_SPEED_KI:    gain_ki = val[23:0];
      cpsc_pkg::REG_SPEED_KD:    gain_kd = val[23:0];
      cpsc_pkg::REG_SPEED_LIMIT: lim_speed = val[23:0];
      cpsc_pkg::REG_DEADBAND:    db_level = val[11:0];
      cpsc_pkg::REG_MOTOR_RPC:   motor_scale = val;
      cpsc_pkg::REG_REF_RPC:     ref_scale = val;
      default: ;
    endcase
  endfunction

  function automatic drive_beat_t control_tick(logic [15:0] mc, logic [15:0] rc);
    drive_beat_t b;
    longint rd, md, tpos, pos, raw, speed, tspeed, es, pt, istep, iold, dt, u, sat;
    longint vmax;
    logic [127:0] acc_mag;
    longint acc;
    longint unsigned mag;
    vmax = longint'(cpsc_pkg::VMAX);
    rd = wrap_diff(rc, ref_prev); ref_prev = rc;
    ref_total = ref_total + 32'(rd);
    tpos = scale_sat(longint'(signed'(ref_total)), ref_scale, cpsc_pkg::SHIFT_Q32,
                     cpsc_pkg::POS_CAP);
    md = wrap_diff(mc, motor_prev); motor_prev = mc;
    motor_total = motor_total + 32'(md);
    pos = scale_sat(longint'(signed'(motor_total)), motor_scale, cpsc_pkg::SHIFT_Q32,
                    cpsc_pkg::POS_CAP);
    raw = scale_sat(md * 500, motor_scale, cpsc_pkg::SHIFT_Q32, cpsc_pkg::S32_CAP);
    acc = longint'(cpsc_pkg::COEF_B0) * raw + longint'(cpsc_pkg::COEF_B1) * filt_x0
        + longint'(cpsc_pkg::COEF_B0) * filt_x1 + longint'(cpsc_pkg::COEF_A0M) * filt_y0
        - longint'(cpsc_pkg::COEF_A1) * filt_y1;
    acc_mag = (acc < 0) ? 128'(-acc) : 128'(acc);
    acc_mag = (acc_mag + (128'd1 << 29)) >> 30;
    if (acc_mag > 128'(cpsc_pkg::S32_CAP)) acc_mag = 128'(cpsc_pkg::S32_CAP);
    speed = (acc < 0) ? -longint'(acc_mag[63:0]) : longint'(acc_mag[63:0]);
    filt_x1 = filt_x0; filt_x0 = raw; filt_y1 = filt_y0; filt_y0 = speed;
    tspeed = scale_sat(tpos - pos, gain_pos, cpsc_pkg::FRAC_BITS, lim_speed);
    es = tspeed - speed;
    pt = scale_sat(es, gain_kp, cpsc_pkg::FRAC_BITS, 64'h7FFF_FFFF_FFFF_FFFF);
    istep = scale_sat(es, gain_ki, cpsc_pkg::FRAC_BITS, 64'h7FFF_FFFF_FFFF_FFFF);
    iold = integ;
    integ = clip_s32(integ + istep);
    dt = -scale_sat(speed - prev_speed, gain_kd, cpsc_pkg::FRAC_BITS,
                    64'h7FFF_FFFF_FFFF_FFFF);
    u = pt + integ + dt;
    sat = u;
    // conditional anti-windup: hold the integrator while pushing into the clamp
    if (u > vmax) begin
      sat = vmax;
      if (es > 0) integ = iold;
    end else if (u < -vmax) begin
      sat = -vmax;
      if (es < 0) integ = iold;
    end
    prev_speed = speed;
    mag = longint'((sat < 0) ? -sat : sat);
    b.duty = '0; b.fwd = 1'b0; b.rev = 1'b0;
    if (mag * cpsc_pkg::PWM_TOP >= longint'(db_level) * vmax) begin
      b.duty = 12'(mag * cpsc_pkg::PWM_TOP / vmax);
      if (sat > 0) b.fwd = 1'b1;
      else b.rev = 1'b1;
    end
    b.pos = pos[47:0]; b.tpos = tpos[47:0];
    b.speed = speed[31:0]; b.volts = sat[18:0];
    return b;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(99) < 40) return 0;
    if ($urandom_range(99) < long_gap_pct) return $urandom_range(60, 20);
    return $urandom_range(3, 1);
  endfunction

  // result side: random stalls on each pending beat and field checks
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        drive_beat_t got, exp_b;
        got.duty  = m_tdata[11:0];
        got.fwd   = m_tdata[12];
        got.rev   = m_tdata[13];
        got.pos   = m_tdata[61:14];
        got.tpos  = m_tdata[109:62];
        got.speed = m_tdata[141:110];
        got.volts = m_tdata[160:142];
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          exp_b = expected_beats.pop_front();
          beats_checked++;
          if (got.duty != exp_b.duty) begin
            $error("pwm_duty exp %0d got %0d", exp_b.duty, got.duty); errors++;
          end
          if (got.fwd != exp_b.fwd) begin
            $error("drive_forward exp %0d got %0d", exp_b.fwd, got.fwd); errors++;
          end
          if (got.rev != exp_b.rev) begin
            $error("drive_reverse exp %0d got %0d", exp_b.rev, got.rev); errors++;
          end
          if (got.pos != exp_b.pos) begin
            $error("motor_pos exp %h got %h", exp_b.pos, got.pos); errors++;
          end
          if (got.tpos != exp_b.tpos) begin
            $error("ref_pos exp %h got %h", exp_b.tpos, got.tpos);
            errors++;
          end
          if (got.speed != exp_b.speed) begin
            $error("filtered_speed exp %h got %h", exp_b.speed, got.speed); errors++;
          end
          if (got.volts != exp_b.volts) begin
            $error("drive_volts exp %h got %h", exp_b.volts, got.volts); errors++;
          end
        end
        m_tready <= 1'b0;
        rdy_wait <= 1'b0;
      end else if (m_tvalid && !m_tready) begin
        if (!rdy_wait) begin
          rdy_hold <= gap_len();
          rdy_wait <= 1'b1;
        end else if (rdy_hold == 0) begin
          m_tready <= 1'b1;
        end else begin
          rdy_hold <= rdy_hold - 1;
        end
      end
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 4000) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_counts(logic [15:0] mc, logic [15:0] rc);
    int g;
    g = gap_len();
    repeat (g) @(posedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {rc, mc};
    do @(posedge clk); while (!s_tready);
    expected_beats.push_back(control_tick(mc, rc));
    beats_sent++;
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    write_model_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed_extremes();
    send_counts(16'h0000, 16'h0000);
    send_counts(16'hFFFF, 16'h0001);
    send_counts(16'h7FFF, 16'h8000);
    send_counts(16'h8000, 16'h7FFF);
    send_counts(16'h0000, 16'hFFFF);
    send_counts(16'h0000, 16'h0000);
    // big step between reference and motor drives the clamp and anti-windup
    for (int i = 0; i < 8; i++) send_counts(16'h0000, 16'(i * 4000));
    for (int i = 0; i < 6; i++) send_counts(16'(i * 5000), 16'h0000);
    drain_results();
    // deadband zero: a zero command gives reverse with zero duty
    write_reg(cpsc_pkg::REG_DEADBAND, 32'd0);
    write_reg(cpsc_pkg::REG_POS_GAIN, 32'd0);
    write_reg(cpsc_pkg::REG_SPEED_KP, 32'd0);
    write_reg(cpsc_pkg::REG_SPEED_KI, 32'd0);
    send_counts(16'h0000, 16'h0000);
    send_counts(16'h0000, 16'h0000);
    drain_results();
    write_reg(SPARE_REG_IDX, 32'hFFFF_FFFF);   // unknown index, ignored
  endtask

  task automatic test_tracking(int n, int step_max);
    logic [15:0] mc, rc;
    mc = motor_prev; rc = ref_prev;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        mc = 16'($urandom); rc = 16'($urandom);
      end else begin
        mc = mc + 16'($urandom_range(2 * step_max) - step_max);
        rc = rc + 16'($urandom_range(2 * step_max) - step_max);
      end
      send_counts(mc, rc);
    end
  endtask

  task automatic test_register_settings();
    logic [31:0] ext[8];
    for (int phase = 0; phase < 6; phase++) begin
      drain_results();
      for (int r = 0; r < 8; r++) begin
        case (phase)
          0: ext[r] = 32'hFFFF_FFFF;
          1: ext[r] = 32'h0;
          default: ext[r] = $urandom;
        endcase
        if (8'(r) == cpsc_pkg::REG_DEADBAND && phase >= 2) ext[r] = $urandom_range(3999);
        if (8'(r) == cpsc_pkg::REG_DEADBAND && phase == 0) ext[r] = 32'd3999;
        if (8'(r) >= cpsc_pkg::REG_MOTOR_RPC && phase >= 2 && $urandom_range(1))
          ext[r] = $urandom_range(1 << 26);
        write_reg(8'(r), ext[r]);
      end
      test_tracking(200, (phase % 2) ? 40 : 2000);
    end
  endtask

  initial begin
    reset_controller_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_extremes();
    drain_results();
    // back to default tuning, loop state carries on
    write_reg(cpsc_pkg::REG_POS_GAIN, 32'd983040);
    write_reg(cpsc_pkg::REG_SPEED_KP, 32'd327680);
    write_reg(cpsc_pkg::REG_SPEED_KI, 32'd3277);
    write_reg(cpsc_pkg::REG_DEADBAND, 32'd100);
    test_tracking(1, 0);
    drain_results();
    test_register_settings();
    long_gap_pct = 0;
    test_tracking(230, 300);
    drain_results();
    $display("sent %0d count beats, checked %0d results", beats_sent, beats_checked);
    $display("covered count wraps, loop clamps, deadband and register extremes");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
